### hdl/swsr_pkg.sv
package swsr_pkg;

    localparam int DEPTH_DEF    = 8;
    localparam int KEY_BITS_DEF = 32;
    localparam int WORD_BITS    = 32;
    localparam int LEVEL_BITS   = 4;

    typedef enum logic [1:0] {
        F_PUSH   = 2'd0,
        F_POP    = 2'd1,
        F_REMOVE = 2'd2,
        F_SEARCH = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic    load;
        logic    push_wr;
        logic    fill_inc;
        logic    fill_dec;
        logic    rd_top;
        logic    rd_down;
        logic    rd_up;
        logic    shift_wr;
        logic    pop_cap;
        logic    set_found;
        logic    status_wr;
        t_status status_val;
        logic    latch_out;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic hit;
        logic at_top;
        logic at_bottom;
    } t_stat;

endpackage

### hdl/swsr_ctrl.sv
module swsr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_func,
    input  swsr_pkg::t_stat  i_stat,
    output swsr_pkg::t_cmd   o_cmd,
    output logic             o_valid
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_EXEC     = 7'b0000010,
        S_POP_WAIT = 7'b0000100,
        S_SCAN     = 7'b0001000,
        S_SHIFT    = 7'b0010000,
        S_TOP_RD   = 7'b0100000,
        S_LATCH    = 7'b1000000
    } t_state;

    t_state          r_state, n_state;
    swsr_pkg::t_func r_func,  n_func;
    logic            r_valid, n_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_func <= n_func;
    end

    always_comb begin
        n_state = r_state;
        n_func  = r_func;
        n_valid = 1'b0;
        o_cmd   = '0;
        o_cmd.status_val = swsr_pkg::ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_func     = swsr_pkg::t_func'(i_func);
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_func) inside
                    swsr_pkg::F_PUSH: begin
                        if (i_stat.full) begin
                            o_cmd.status_wr  = 1'b1;
                            o_cmd.status_val = swsr_pkg::ST_FULL;
                        end else begin
                            o_cmd.push_wr  = 1'b1;
                            o_cmd.fill_inc = 1'b1;
                        end
                        n_state = S_TOP_RD;
                    end
                    swsr_pkg::F_POP: begin
                        if (i_stat.empty) begin
                            o_cmd.status_wr  = 1'b1;
                            o_cmd.status_val = swsr_pkg::ST_EMPTY;
                            n_state          = S_TOP_RD;
                        end else begin
                            o_cmd.rd_top = 1'b1;
                            n_state      = S_POP_WAIT;
                        end
                    end
                    swsr_pkg::F_REMOVE, swsr_pkg::F_SEARCH: begin
                        if (i_stat.empty) begin
                            o_cmd.status_wr  = 1'b1;
                            o_cmd.status_val = (r_func == swsr_pkg::F_REMOVE) ?
                                               swsr_pkg::ST_EMPTY : swsr_pkg::ST_NOTFOUND;
                            n_state          = S_TOP_RD;
                        end else begin
                            o_cmd.rd_top = 1'b1;
                            n_state      = S_SCAN;
                        end
                    end
                    default: n_state = S_TOP_RD;
                endcase
            end
            S_POP_WAIT: begin
                o_cmd.pop_cap  = 1'b1;
                o_cmd.fill_dec = 1'b1;
                n_state        = S_TOP_RD;
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    o_cmd.set_found = 1'b1;
                    if (r_func == swsr_pkg::F_SEARCH) begin
                        n_state = S_TOP_RD;
                    end else if (i_stat.at_top) begin
                        o_cmd.fill_dec = 1'b1;
                        n_state        = S_TOP_RD;
                    end else begin
                        o_cmd.rd_up = 1'b1;
                        n_state     = S_SHIFT;
                    end
                end else if (i_stat.at_bottom) begin
                    o_cmd.status_wr  = 1'b1;
                    o_cmd.status_val = swsr_pkg::ST_NOTFOUND;
                    n_state          = S_TOP_RD;
                end else begin
                    o_cmd.rd_down = 1'b1;
                end
            end
            S_SHIFT: begin
                o_cmd.shift_wr = 1'b1;
                if (i_stat.at_top) begin
                    o_cmd.fill_dec = 1'b1;
                    n_state        = S_TOP_RD;
                end else begin
                    o_cmd.rd_up = 1'b1;
                end
            end
            S_TOP_RD: begin
                o_cmd.rd_top = 1'b1;
                n_state      = S_LATCH;
            end
            S_LATCH: begin
                o_cmd.latch_out = 1'b1;
                n_valid         = 1'b1;
                n_state         = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;

`ifndef NO_ASSERTIONS
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe longer than one cycle");
    a_valid_after_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LATCH) |=> (r_valid && r_state == S_IDLE))
        else $error("result not presented after latch");
    a_shift_only_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_func == swsr_pkg::F_REMOVE))
        else $error("compaction outside remove");
`endif

endmodule

### hdl/swsr_dpath.sv
module swsr_dpath #(
    parameter int DEPTH    = swsr_pkg::DEPTH_DEF,
    parameter int KEY_BITS = swsr_pkg::KEY_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [swsr_pkg::WORD_BITS-1:0]   i_key,
    input  swsr_pkg::t_cmd                   i_cmd,
    output swsr_pkg::t_stat                  o_stat,
    output logic [1:0]                       o_status,
    output logic                             o_found,
    output logic [swsr_pkg::WORD_BITS-1:0]   o_popped_key,
    output logic                             o_top_valid,
    output logic [swsr_pkg::WORD_BITS-1:0]   o_top_key,
    output logic [swsr_pkg::LEVEL_BITS-1:0]  o_level
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WB = swsr_pkg::WORD_BITS;

    logic [KEY_BITS-1:0] mem [DEPTH];

    logic [CW-1:0]       r_fill;
    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] r_rd_data;
    logic [AW-1:0]       r_rd_addr;
    swsr_pkg::t_status   r_status;
    logic                r_found;
    logic [WB-1:0]       r_popped;
    logic                r_top_valid;
    logic [WB-1:0]       r_top_key;
    logic [swsr_pkg::LEVEL_BITS-1:0] r_level;

    logic [63:0]   key_ext;
    logic [63:0]   rd_ext;
    logic [63:0]   fill_ext;
    logic [CW-1:0] fill_m1;
    logic [AW-1:0] top_addr;
    logic [AW-1:0] rd_sel;
    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [KEY_BITS-1:0] wr_data;
    logic          empty;
    logic          full;

    assign key_ext  = 64'(i_key);
    assign rd_ext   = 64'(r_rd_data);
    assign fill_ext = 64'(r_fill);
    assign fill_m1  = r_fill - CW'(1);
    assign top_addr = fill_m1[AW-1:0];
    assign empty    = (r_fill == '0);
    assign full     = (r_fill == CW'(DEPTH));

    always_comb begin
        rd_sel = top_addr;
        if (i_cmd.rd_down) begin
            rd_sel = r_rd_addr - AW'(1);
        end else if (i_cmd.rd_up) begin
            rd_sel = r_rd_addr + AW'(1);
        end
    end

    assign rd_en   = i_cmd.rd_top | i_cmd.rd_down | i_cmd.rd_up;
    assign wr_en   = i_cmd.push_wr | i_cmd.shift_wr;
    assign wr_addr = i_cmd.push_wr ? r_fill[AW-1:0] : (r_rd_addr - AW'(1));
    assign wr_data = i_cmd.push_wr ? r_key : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_sel];
            r_rd_addr <= rd_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_status <= swsr_pkg::ST_OK;
            r_found  <= 1'b0;
        end else begin
            if (i_cmd.fill_inc) begin
                r_fill <= r_fill + CW'(1);
            end else if (i_cmd.fill_dec) begin
                r_fill <= fill_m1;
            end
            if (i_cmd.load) begin
                r_status <= swsr_pkg::ST_OK;
                r_found  <= 1'b0;
            end else begin
                if (i_cmd.status_wr) begin
                    r_status <= i_cmd.status_val;
                end
                if (i_cmd.set_found) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key    <= key_ext[KEY_BITS-1:0];
            r_popped <= '0;
        end else if (i_cmd.pop_cap) begin
            r_popped <= rd_ext[WB-1:0];
        end
        if (i_cmd.latch_out) begin
            r_top_valid <= !empty;
            r_top_key   <= empty ? '0 : rd_ext[WB-1:0];
            r_level     <= fill_ext[swsr_pkg::LEVEL_BITS-1:0];
        end
    end

    assign o_stat.empty     = empty;
    assign o_stat.full      = full;
    assign o_stat.hit       = (r_rd_data == r_key);
    assign o_stat.at_top    = (r_rd_addr == top_addr);
    assign o_stat.at_bottom = (r_rd_addr == '0);

    assign o_status     = r_status;
    assign o_found      = r_found;
    assign o_popped_key = r_popped;
    assign o_top_valid  = r_top_valid;
    assign o_top_key    = r_top_key;
    assign o_level      = r_level;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(DEPTH))
        else $error("fill count above depth");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill_inc |-> !full)
        else $error("increment on full stack");
    a_no_dec_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill_dec |-> !empty)
        else $error("decrement on empty stack");
    a_shift_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift_wr |-> (r_rd_addr != '0))
        else $error("compaction write below bottom");
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_status == swsr_pkg::ST_OK))
        else $error("found with error status");
`endif

endmodule

### hdl/stack_with_search_remove_core.sv
// An accepted start runs the operation, then reads the top entry and latches the result
// for the o_valid strobe; search and remove scan down from the top to the match (to the
// bottom without one); remove then moves the entries above it down. One memory read port,
// one entry per cycle, sets the scan and compaction time; next start in the strobe cycle.
// Reset is synchronous, active low: it empties the stack and idles the controller;
// stored entries are not cleared. Results cannot be stalled.
module stack_with_search_remove_core #(
    parameter int DEPTH    = swsr_pkg::DEPTH_DEF,
    parameter int KEY_BITS = swsr_pkg::KEY_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       i_func,
    input  logic [swsr_pkg::WORD_BITS-1:0]   i_key,
    output logic                             o_valid,
    output logic [1:0]                       o_status,
    output logic                             o_found,
    output logic [swsr_pkg::WORD_BITS-1:0]   o_popped_key,
    output logic                             o_top_valid,
    output logic [swsr_pkg::WORD_BITS-1:0]   o_top_key,
    output logic [swsr_pkg::LEVEL_BITS-1:0]  o_level
);

    swsr_pkg::t_cmd  cmd;
    swsr_pkg::t_stat stat;

    swsr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_func  (i_func),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_valid (o_valid)
    );

    swsr_dpath #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key        (i_key),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_status     (o_status),
        .o_found      (o_found),
        .o_popped_key (o_popped_key),
        .o_top_valid  (o_top_valid),
        .o_top_key    (o_top_key),
        .o_level      (o_level)
    );

endmodule

### verif/tb_stack_with_search_remove_core.sv
`timescale 1ns / 100ps

module tb_stack_with_search_remove_core;

    localparam int DEPTH       = swsr_pkg::DEPTH_DEF;
    localparam int WB          = swsr_pkg::WORD_BITS;
    localparam int LB          = swsr_pkg::LEVEL_BITS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 2 * DEPTH + 8;

    typedef struct packed {
        swsr_pkg::t_status       status;
        logic                    found;
        logic [WB-1:0]           popped_key;
        logic                    top_valid;
        logic [WB-1:0]           top_key;
        logic [LB-1:0]           level;
    } t_stack_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [1:0]              i_func = swsr_pkg::F_PUSH;
    logic [WB-1:0]           i_key = '0;
    logic                    o_valid;
    logic [1:0]              o_status;
    logic                    o_found;
    logic [WB-1:0]           o_popped_key;
    logic                    o_top_valid;
    logic [WB-1:0]           o_top_key;
    logic [LB-1:0]           o_level;

    logic [WB-1:0]           shadow_entries [DEPTH];
    int                      shadow_fill = 0;
    t_stack_result           pending_results [$];
    logic [WB-1:0]           key_pool [6];
    int                      sender_idle_pct = 0;
    int                      fail_count = 0;
    int                      cycle_count = 0;

    stack_with_search_remove_core #(
        .DEPTH    (DEPTH),
        .KEY_BITS (swsr_pkg::KEY_BITS_DEF)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_key        (i_key),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_found      (o_found),
        .o_popped_key (o_popped_key),
        .o_top_valid  (o_top_valid),
        .o_top_key    (o_top_key),
        .o_level      (o_level)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic t_stack_result stack_predict(input swsr_pkg::t_func func,
                                                    input logic [WB-1:0] key);
        t_stack_result res;
        int pos;
        res = '0;
        res.status = swsr_pkg::ST_OK;
        pos = -1;
        case (func)
            swsr_pkg::F_PUSH: begin
                if (shadow_fill >= DEPTH) begin
                    res.status = swsr_pkg::ST_FULL;
                end else begin
                    shadow_entries[shadow_fill] = key;
                    shadow_fill++;
                end
            end
            swsr_pkg::F_POP: begin
                if (shadow_fill == 0) begin
                    res.status = swsr_pkg::ST_EMPTY;
                end else begin
                    shadow_fill--;
                    res.popped_key = shadow_entries[shadow_fill];
                end
            end
            swsr_pkg::F_REMOVE: begin
                if (shadow_fill == 0) begin
                    res.status = swsr_pkg::ST_EMPTY;
                end else begin
                    for (int i = shadow_fill - 1; i >= 0; i--) begin
                        if (pos < 0 && shadow_entries[i] == key) pos = i;
                    end
                    if (pos < 0) begin
                        res.status = swsr_pkg::ST_NOTFOUND;
                    end else begin
                        for (int i = pos; i + 1 < shadow_fill; i++)
                            shadow_entries[i] = shadow_entries[i + 1];
                        shadow_fill--;
                        res.found = 1'b1;
                    end
                end
            end
            default: begin
                for (int i = 0; i < shadow_fill; i++) begin
                    if (shadow_entries[i] == key) res.found = 1'b1;
                end
                res.status = res.found ? swsr_pkg::ST_OK : swsr_pkg::ST_NOTFOUND;
            end
        endcase
        res.top_valid = (shadow_fill > 0);
        res.top_key   = (shadow_fill > 0) ? shadow_entries[shadow_fill - 1] : '0;
        res.level     = LB'(shadow_fill);
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [WB-1:0] exp_val,
                                 input logic [WB-1:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_stack_result exp_res;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("result word with no expectation waiting");
                fail_count++;
            end else begin
                exp_res = pending_results.pop_front();
                compare_field("status", WB'(exp_res.status), WB'(o_status));
                compare_field("found", WB'(exp_res.found), WB'(o_found));
                compare_field("popped_key", exp_res.popped_key, o_popped_key);
                compare_field("top_valid", WB'(exp_res.top_valid), WB'(o_top_valid));
                compare_field("top_key", exp_res.top_key, o_top_key);
                compare_field("level", WB'(exp_res.level), WB'(o_level));
            end
        end
    end

    task automatic send_word(input swsr_pkg::t_func func, input logic [WB-1:0] key);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_func <= func;
        i_key  <= key;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(stack_predict(func, key));
    endtask

    task automatic stop_sending();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_empty_requests();
        send_word(swsr_pkg::F_POP, $urandom);
        send_word(swsr_pkg::F_REMOVE, 32'h0000_1234);
        send_word(swsr_pkg::F_SEARCH, '0);
    endtask

    task automatic test_fill_and_full();
        send_word(swsr_pkg::F_PUSH, '0);
        send_word(swsr_pkg::F_PUSH, '1);
        send_word(swsr_pkg::F_PUSH, 32'hA5A5_A5A5);
        send_word(swsr_pkg::F_PUSH, 32'h5A5A_5A5A);
        send_word(swsr_pkg::F_PUSH, 32'h0000_0011);
        send_word(swsr_pkg::F_PUSH, 32'h0000_0022);
        send_word(swsr_pkg::F_PUSH, 32'h0000_0011);
        send_word(swsr_pkg::F_PUSH, 32'h8000_0001);
        send_word(swsr_pkg::F_PUSH, 32'hDEAD_BEEF);
    endtask

    task automatic test_search_and_remove();
        send_word(swsr_pkg::F_SEARCH, '0);
        send_word(swsr_pkg::F_SEARCH, 32'h8000_0001);
        send_word(swsr_pkg::F_SEARCH, 32'h0000_0033);
        // topmost of the duplicates goes, entries above it move down
        send_word(swsr_pkg::F_REMOVE, 32'h0000_0011);
        send_word(swsr_pkg::F_REMOVE, 32'h8000_0001);
        send_word(swsr_pkg::F_REMOVE, '0);
        send_word(swsr_pkg::F_REMOVE, 32'h0000_0099);
        repeat (6) send_word(swsr_pkg::F_POP, $urandom);
    endtask

    function automatic logic [WB-1:0] pick_key(input swsr_pkg::t_func func);
        int r;
        r = $urandom_range(99);
        if (func == swsr_pkg::F_POP) return $urandom;
        if (func != swsr_pkg::F_PUSH && shadow_fill > 0 && r < 60)
            return shadow_entries[$urandom_range(shadow_fill - 1)];
        if (r < 80) return key_pool[$urandom_range(5)];
        return $urandom;
    endfunction

    task automatic test_random_traffic(input int count, input int idle_pct);
        int mode;
        int r;
        swsr_pkg::t_func func;
        for (int n = 0; n < count; n++) begin
            if (n % 16 == 0) begin
                mode = $urandom_range(2);
                sender_idle_pct = ($urandom_range(3) == 0) ? 0 : idle_pct;
            end
            r = $urandom_range(99);
            case (mode)
                0: begin
                    func = (r < 55) ? swsr_pkg::F_PUSH :
                           (r < 70) ? swsr_pkg::F_POP :
                           (r < 85) ? swsr_pkg::F_REMOVE : swsr_pkg::F_SEARCH;
                end
                1: begin
                    func = (r < 20) ? swsr_pkg::F_PUSH :
                           (r < 60) ? swsr_pkg::F_POP :
                           (r < 80) ? swsr_pkg::F_REMOVE : swsr_pkg::F_SEARCH;
                end
                default: begin
                    func = (r < 30) ? swsr_pkg::F_PUSH :
                           (r < 55) ? swsr_pkg::F_POP :
                           (r < 80) ? swsr_pkg::F_REMOVE : swsr_pkg::F_SEARCH;
                end
            endcase
            send_word(func, pick_key(func));
        end
        sender_idle_pct = 0;
    endtask

    initial begin
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 6; i++) key_pool[i] = $urandom;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_requests();
        test_fill_and_full();
        test_search_and_remove();
        test_random_traffic(425, 0);
        test_random_traffic(425, 69);
        test_random_traffic(425, 0);
        test_random_traffic(425, 14);
        stop_sending();

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### sim.f
hdl/swsr_pkg.sv
hdl/swsr_ctrl.sv
hdl/swsr_dpath.sv
hdl/stack_with_search_remove_core.sv
verif/tb_stack_with_search_remove_core.sv
